// ===== rtl/first_fit_page_allocator_top_macros.svh =====
// assertion macros for the first fit page allocator
// used by the checker file; needs clk and rst_n in scope
`ifndef FIRST_FIT_PAGE_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_PAGE_ALLOCATOR_TOP_MACROS_SVH
// antecedent implies consequent in the same cycle
`define FFPA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffpa check failed");
// antecedent implies consequent in the next cycle
`define FFPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffpa check failed");
`endif

// ===== rtl/ffpa_pkg.sv =====
// shared constants, codes and types of the first fit page allocator
// no dependencies
`default_nettype none
package ffpa_pkg;
    localparam int MAX_PAGES   = 256;
    localparam int MAX_HANDLES = 16;
    localparam int PAGE_BYTES  = 16384;
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int PIDX_W      = $clog2(MAX_PAGES);
    localparam int SLOT_W      = $clog2(MAX_HANDLES);

    localparam logic [2:0] OP_ALLOC     = 3'd0;
    localparam logic [2:0] OP_RELEASE   = 3'd1;
    localparam logic [2:0] OP_TRANSLATE = 3'd2;
    localparam logic [2:0] OP_QUERY     = 3'd3;
    localparam logic [2:0] OP_CLEAR     = 3'd4;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NOT_ATT    = 3'd1;
    localparam logic [2:0] ST_BAD_COUNT  = 3'd2;
    localparam logic [2:0] ST_NO_SPACE   = 3'd3;
    localparam logic [2:0] ST_NO_SLOT    = 3'd4;
    localparam logic [2:0] ST_BAD_HANDLE = 3'd5;
    localparam logic [2:0] ST_RANGE      = 3'd6;

    localparam logic REG_ARENA_SIZE = 1'b0;

    typedef struct packed {
        logic [2:0]  operation;
        logic [4:0]  handle;
        logic [8:0]  page_count;
        logic [21:0] byte_offset;
        logic [15:0] byte_count;
        logic        handle_ok;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } qhead_t;

    typedef struct packed {
        logic       wr;
        logic [8:0] value;
    } cfg_t;
endpackage
`default_nettype wire

// ===== rtl/ffpa_if.sv =====
// request and result channel interfaces of the page allocator
// no dependencies
`default_nettype none
interface ffpa_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [4:0]  handle;
    logic [8:0]  page_count;
    logic [21:0] byte_offset;
    logic [15:0] byte_count;
    modport source (output valid, operation, handle, page_count, byte_offset, byte_count,
                    input ready);
    modport sink (input valid, operation, handle, page_count, byte_offset, byte_count,
                  output ready);
endinterface

interface ffpa_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [4:0]  handle_out;
    logic [7:0]  first_page;
    logic [8:0]  owned_pages;
    logic [21:0] arena_address;
    logic [8:0]  unowned_pages;
    logic [4:0]  handles_in_use;
    modport source (output valid, status, handle_out, first_page, owned_pages,
                    arena_address, unowned_pages, handles_in_use, input ready);
    modport sink (input valid, status, handle_out, first_page, owned_pages,
                  arena_address, unowned_pages, handles_in_use, output ready);
endinterface
`default_nettype wire

// ===== rtl/first_fit_page_allocator_top.sv =====
// flow: an accepted request waits in the queue until the idle back end takes it, and its result
// is registered; allocate adds the first-fit scan, one page a cycle, plus one end check when no
// run fits; release, translate, query and clear go straight from the idle state to the reply
// the back end works on one item at a time and takes the next after the result is registered;
// a two entry queue in front and the result register behind let each side stall on its own
// reset: rst_n clears handle table, counts and arena size at once; top of ffpa_front/ffpa_back
`default_nettype none
module first_fit_page_allocator_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    ffpa_req_if.sink         req,
    ffpa_res_if.source       res
);
    import ffpa_pkg::*;

    qhead_t     head;
    logic       pop;
    cfg_t       cfg;
    logic [8:0] arena_size;

    assign pready = 1'b1;
    assign cfg    = {(psel && penable && pwrite && (paddr[2] == REG_ARENA_SIZE)), pwdata[8:0]};
    assign prdata = (paddr[2] == REG_ARENA_SIZE) ? {23'd0, arena_size} : 32'd0;

    ffpa_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .head  (head),
        .pop   (pop)
    );

    ffpa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .cfg        (cfg),
        .arena_size (arena_size),
        .res        (res)
    );
endmodule
`default_nettype wire

// ===== rtl/ffpa_front.sv =====
// front end: accepts requests, classifies the handle, two entry queue
// depends on ffpa_pkg and ffpa_if
`default_nettype none
module ffpa_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    ffpa_req_if.sink             req,
    output ffpa_pkg::qhead_t     head,
    input  wire logic            pop
);
    import ffpa_pkg::*;

    item_t      q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    item_t      in_item;

    assign req.ready = (cnt_reg != 2'd2);
    assign push      = req.valid && req.ready;

    always_comb
    begin
        in_item.operation   = req.operation;
        in_item.handle      = req.handle;
        in_item.page_count  = req.page_count;
        in_item.byte_offset = req.byte_offset;
        in_item.byte_count  = req.byte_count;
        in_item.handle_ok   = (req.handle != 5'd0) && (req.handle <= 5'(MAX_HANDLES));
    end

    assign head = {(cnt_reg != 2'd0), q_reg[rd_ptr_reg]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                q_reg[wr_ptr_reg] <= in_item;
                wr_ptr_reg        <= ~wr_ptr_reg;
            end
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/ffpa_back.sv =====
// back end: handle table with page range lookup, first-fit scan sequencer, result register
// depends on ffpa_pkg and ffpa_if
`default_nettype none
module ffpa_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ffpa_pkg::qhead_t head,
    output logic                  pop,
    input  wire ffpa_pkg::cfg_t   cfg,
    output logic [8:0]            arena_size,
    ffpa_res_if.source            res
);
    import ffpa_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_REPLY = 2'd2;

    logic [1:0]        state_reg;
    logic [8:0]        total_reg;
    logic              slot_used_reg [MAX_HANDLES];
    logic [7:0]        slot_start_reg [MAX_HANDLES];
    logic [8:0]        slot_pages_reg [MAX_HANDLES];
    logic [8:0]        free_reg;
    logic [4:0]        hcnt_reg;
    logic [8:0]        count_reg;
    logic [8:0]        p_reg;
    logic [8:0]        run_len_reg;
    logic [7:0]        run_start_reg;
    logic [2:0]        r_status_reg;
    logic [4:0]        r_hout_reg;
    logic [7:0]        r_start_reg;
    logic [8:0]        r_owned_reg;
    logic [21:0]       r_addr_reg;
    logic              out_valid_reg;
    logic [2:0]        o_status_reg;
    logic [4:0]        o_hout_reg;
    logic [7:0]        o_start_reg;
    logic [8:0]        o_owned_reg;
    logic [21:0]       o_addr_reg;
    logic [8:0]        o_free_reg;
    logic [4:0]        o_hcnt_reg;

    logic [SLOT_W-1:0] hslot;
    logic              hfound;
    logic              free_slot_ok;
    logic [SLOT_W-1:0] free_slot;
    logic [22:0]       need;
    logic [22:0]       size;
    logic [8:0]        run_inc;
    logic [8:0]        cfg_cap;
    logic              page_busy;
    logic              out_free;
    item_t             it;

    assign it          = head.item;
    assign arena_size  = total_reg;
    assign hslot       = SLOT_W'(it.handle - 5'd1);
    assign hfound      = it.handle_ok && slot_used_reg[hslot];
    assign need        = {1'b0, it.byte_offset} + {7'd0, it.byte_count};
    assign size        = 23'(slot_pages_reg[hslot]) << PAGE_SHIFT;
    assign run_inc     = run_len_reg + 9'd1;
    assign cfg_cap     = (cfg.value > 9'(MAX_PAGES)) ? 9'(MAX_PAGES) : cfg.value;
    assign pop         = (state_reg == S_IDLE) && head.valid && !cfg.wr;
    assign out_free    = !out_valid_reg || res.ready;

    // lowest free handle slot
    always_comb
    begin
        free_slot_ok = 1'b0;
        free_slot    = '0;
        for (int i = MAX_HANDLES - 1; i >= 0; i--)
        begin
            if (!slot_used_reg[i])
            begin
                free_slot_ok = 1'b1;
                free_slot    = SLOT_W'(i);
            end
        end
    end

    // a page is owned when it lies inside the range of an allocated handle
    always_comb
    begin
        page_busy = 1'b0;
        for (int i = 0; i < MAX_HANDLES; i++)
        begin
            if (slot_used_reg[i] && ({1'b0, p_reg} >= {2'b00, slot_start_reg[i]})
                && ({1'b0, p_reg} < ({2'b00, slot_start_reg[i]} + {1'b0, slot_pages_reg[i]})))
                page_busy = 1'b1;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.status         = o_status_reg;
    assign res.handle_out     = o_hout_reg;
    assign res.first_page     = o_start_reg;
    assign res.owned_pages    = o_owned_reg;
    assign res.arena_address  = o_addr_reg;
    assign res.unowned_pages  = o_free_reg;
    assign res.handles_in_use = o_hcnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            free_reg      <= '0;
            hcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_HANDLES; i++)
                slot_used_reg[i] <= 1'b0;
        end
        else
        begin
            if ((state_reg == S_REPLY) && out_free)
                out_valid_reg <= 1'b1;
            else if (res.valid && res.ready)
                out_valid_reg <= 1'b0;

            if (cfg.wr)
            begin
                total_reg <= cfg_cap;
                free_reg  <= cfg_cap;
                hcnt_reg  <= '0;
                for (int i = 0; i < MAX_HANDLES; i++)
                    slot_used_reg[i] <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        count_reg    <= it.page_count;
                        r_status_reg <= ST_OK;
                        r_hout_reg   <= '0;
                        r_start_reg  <= '0;
                        r_owned_reg  <= '0;
                        r_addr_reg   <= '0;
                        state_reg    <= S_REPLY;
                        unique case (it.operation)
                            OP_ALLOC:
                            begin
                                if (total_reg == 9'd0)
                                    r_status_reg <= ST_NOT_ATT;
                                else if (it.page_count == 9'd0)
                                    r_status_reg <= ST_BAD_COUNT;
                                else
                                begin
                                    p_reg       <= '0;
                                    run_len_reg <= '0;
                                    state_reg   <= S_SCAN;
                                end
                            end
                            OP_RELEASE:
                            begin
                                if (!hfound)
                                    r_status_reg <= ST_BAD_HANDLE;
                                else
                                begin
                                    free_reg              <= free_reg + slot_pages_reg[hslot];
                                    hcnt_reg              <= hcnt_reg - 5'd1;
                                    slot_used_reg[hslot]  <= 1'b0;
                                    slot_start_reg[hslot] <= '0;
                                    slot_pages_reg[hslot] <= '0;
                                end
                            end
                            OP_TRANSLATE:
                            begin
                                if (total_reg == 9'd0)
                                    r_status_reg <= ST_NOT_ATT;
                                else if (!hfound)
                                    r_status_reg <= ST_BAD_HANDLE;
                                else
                                begin
                                    r_start_reg <= slot_start_reg[hslot];
                                    r_owned_reg <= slot_pages_reg[hslot];
                                    if (need > size)
                                        r_status_reg <= ST_RANGE;
                                    else
                                        r_addr_reg <= (22'(slot_start_reg[hslot]) << PAGE_SHIFT)
                                                      + it.byte_offset;
                                end
                            end
                            OP_QUERY:
                            begin
                                if (!hfound)
                                    r_status_reg <= ST_BAD_HANDLE;
                                else
                                begin
                                    r_start_reg <= slot_start_reg[hslot];
                                    r_owned_reg <= slot_pages_reg[hslot];
                                end
                            end
                            OP_CLEAR:
                            begin
                                free_reg <= total_reg;
                                hcnt_reg <= '0;
                                for (int i = 0; i < MAX_HANDLES; i++)
                                    slot_used_reg[i] <= 1'b0;
                            end
                            default:
                            begin
                                r_status_reg <= ST_OK;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (p_reg >= total_reg)
                    begin
                        r_status_reg <= ST_NO_SPACE;
                        state_reg    <= S_REPLY;
                    end
                    else if (!page_busy)
                    begin
                        if (run_len_reg == 9'd0)
                            run_start_reg <= p_reg[PIDX_W-1:0];
                        run_len_reg <= run_inc;
                        p_reg       <= p_reg + 9'd1;
                        if (run_inc >= count_reg)
                        begin
                            state_reg <= S_REPLY;
                            if (!free_slot_ok)
                                r_status_reg <= ST_NO_SLOT;
                            else
                            begin
                                // run found: the start is p itself when the run is fresh
                                slot_used_reg[free_slot]  <= 1'b1;
                                slot_start_reg[free_slot] <= (run_len_reg == 9'd0)
                                                             ? p_reg[PIDX_W-1:0] : run_start_reg;
                                slot_pages_reg[free_slot] <= count_reg;
                                free_reg    <= free_reg - count_reg;
                                hcnt_reg    <= hcnt_reg + 5'd1;
                                r_hout_reg  <= 5'(free_slot) + 5'd1;
                                r_start_reg <= (run_len_reg == 9'd0)
                                               ? p_reg[PIDX_W-1:0] : run_start_reg;
                                r_owned_reg <= count_reg;
                            end
                        end
                    end
                    else
                    begin
                        run_len_reg <= '0;
                        p_reg       <= p_reg + 9'd1;
                    end
                end
                S_REPLY:
                begin
                    // wait here while the previous transaction still sits on the port
                    if (out_free)
                    begin
                        o_status_reg <= r_status_reg;
                        o_hout_reg   <= r_hout_reg;
                        o_start_reg  <= r_start_reg;
                        o_owned_reg  <= r_owned_reg;
                        o_addr_reg   <= r_addr_reg;
                        o_free_reg   <= free_reg;
                        o_hcnt_reg   <= hcnt_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/ffpa_checker.sv =====
// port level checks on the allocator result channel, bound to the top level
// depends on first_fit_page_allocator_top_macros.svh and ffpa_pkg
`default_nettype none
`include "first_fit_page_allocator_top_macros.svh"
module ffpa_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic [2:0] status,
    input wire logic [4:0] handle_out,
    input wire logic [8:0] owned_pages,
    input wire logic [8:0] unowned_pages,
    input wire logic [4:0] handles_in_use
);
    import ffpa_pkg::*;

    // a stalled transaction stays on the port
    `FFPA_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid)
    // a granted handle only comes with success and a non-empty grant
    `FFPA_ASSERT_NOW(a_grant_ok, res_valid && (handle_out != 5'd0), (status == ST_OK) && (owned_pages != 9'd0) && (handles_in_use != 5'd0))
    `FFPA_ASSERT_NOW(a_counts, res_valid, (unowned_pages <= 9'(MAX_PAGES)) && (handles_in_use <= 5'(MAX_HANDLES)))
    `FFPA_ASSERT_NOW(a_status, res_valid, status <= ST_RANGE)
endmodule

bind first_fit_page_allocator_top ffpa_checker u_ffpa_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .status         (res.status),
    .handle_out     (res.handle_out),
    .owned_pages    (res.owned_pages),
    .unowned_pages  (res.unowned_pages),
    .handles_in_use (res.handles_in_use)
);
`default_nettype wire
